// ----- src/pms_pkg.sv -----
// Package for the Potts Metropolis step engine: widths, mode codes, the
// request bundle for the acceptance unit and the exp table builder.
// No dependencies.
package pms_pkg;

    // Default sizes
    localparam int NUM_POS_DEF   = 64;
    localparam int NUM_RES_DEF   = 21;
    localparam int EXP_DEPTH_DEF = 256;
    localparam int EXP_DEPTH_MAX = 1024;

    // Fixed field widths
    localparam int MODE_W   = 3;
    localparam int POS_W    = 6;
    localparam int RES_W    = 5;
    localparam int VAL_W    = 32;
    localparam int ENERGY_W = 48;
    localparam int DE_W     = 40;
    localparam int RAND_W   = 16;
    // dE is Q.16 and the table spans 16.0, so index = dE*depth >> 20
    localparam int EXP_SHIFT = 20;

    // Mode codes
    localparam logic [MODE_W-1:0] MODE_FIELD      = 3'd0;
    localparam logic [MODE_W-1:0] MODE_COUPLING   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SET_RES    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SET_ENERGY = 3'd3;
    localparam logic [MODE_W-1:0] MODE_TRIAL      = 3'd4;
    localparam logic [MODE_W-1:0] MODE_READ_RES   = 3'd5;

    // Request to the acceptance unit
    typedef struct packed {
        logic signed [DE_W-1:0] de;
        logic [RAND_W-1:0]      u;
    } acc_req_t;

    typedef logic [RAND_W-1:0] exp_tab_t [EXP_DEPTH_MAX];

    // Shift-subtract divide, elaboration time only
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] rem;
        q   = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--)
        begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den})
            begin
                rem  = rem - {1'b0, den};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // 65536*exp(-16k/depth): Taylor series at x/16, then squared four times
    function automatic logic [RAND_W-1:0] exp_entry(input int k, input int depth);
        logic [63:0] f;
        logic [63:0] term;
        logic [63:0] pos_sum;
        logic [63:0] neg_sum;
        logic [63:0] e;
        f       = udiv64(64'(k) << 31, 64'(depth));
        term    = 64'd1 << 31;
        pos_sum = term;
        neg_sum = '0;
        for (int n = 1; n <= 24; n++)
        begin
            term = udiv64((term * f) >> 31, 64'(n));
            if (n % 2 == 1)
            begin
                neg_sum = neg_sum + term;
            end
            else
            begin
                pos_sum = pos_sum + term;
            end
        end
        e = pos_sum - neg_sum;
        for (int s = 0; s < 4; s++)
        begin
            e = (e * e + (64'd1 << 30)) >> 31;
        end
        e = (e + (64'd1 << 14)) >> 15;
        return (e > 64'd65535) ? 16'hFFFF : e[RAND_W-1:0];
    endfunction

    function automatic exp_tab_t build_exp_tab(input int depth);
        exp_tab_t t;
        for (int k = 0; k < EXP_DEPTH_MAX; k++)
        begin
            if (k < depth)
            begin
                t[k] = exp_entry(k, depth);
            end
            else
            begin
                t[k] = '0;
            end
        end
        return t;
    endfunction

endpackage

// ----- src/pms_ram.sv -----
// Generic synchronous RAM: one write port, two registered read ports.
// No dependencies.
module pms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_a_reg;
    logic [WIDTH-1:0] rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_a_reg <= mem[raddr_a];
        rd_b_reg <= mem[raddr_b];
    end

    assign rdata_a = rd_a_reg;
    assign rdata_b = rd_b_reg;

endmodule

// ----- src/pms_accept.sv -----
// Metropolis acceptance: scales dE to an exp table index and compares the
// random value against the entry. Depends on pms_pkg.
module pms_accept #(
    parameter int EXP_TABLE_DEPTH = pms_pkg::EXP_DEPTH_DEF
) (
    input  logic              clk,
    input  pms_pkg::acc_req_t req,
    output logic              keep
);

    localparam int IW     = $clog2(EXP_TABLE_DEPTH);
    localparam int PROD_W = pms_pkg::DE_W + IW + 1;
    localparam pms_pkg::exp_tab_t EXP_TAB = pms_pkg::build_exp_tab(EXP_TABLE_DEPTH);

    logic [PROD_W-1:0]          prod_reg;
    logic [PROD_W-1:0]          prod_next;
    logic                       neg_reg;
    logic [pms_pkg::RAND_W-1:0] u_reg;
    logic [PROD_W-1:0]          idx;
    logic                       in_range;
    logic [pms_pkg::RAND_W-1:0] entry;

    // scale stage
    assign prod_next = PROD_W'($unsigned(req.de)) * PROD_W'(EXP_TABLE_DEPTH);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        neg_reg  <= req.de[pms_pkg::DE_W-1];
        u_reg    <= req.u;
    end

    // table lookup and compare; dE of 16.0 or more rejects
    assign idx      = prod_reg >> pms_pkg::EXP_SHIFT;
    assign in_range = idx < PROD_W'(EXP_TABLE_DEPTH);
    assign entry    = EXP_TAB[idx[IW-1:0]];
    assign keep     = neg_reg || (in_range && (u_reg < entry));

endmodule

// ----- src/potts_metropolis_step.sv -----
// Potts Metropolis single-site update engine, top level. Depends on pms_pkg,
// pms_ram and pms_accept.
// A trial runs the position loop, which reads one sequence entry and two
// couplings per cycle.
// One item at a time; ready again the cycle after its result is registered.
// Reset clears the sequence (valid bits), the energy and all control state;
// field and coupling memories are undefined until written.
module potts_metropolis_step #(
    parameter int NUM_POS         = pms_pkg::NUM_POS_DEF,
    parameter int NUM_RES         = pms_pkg::NUM_RES_DEF,
    parameter int EXP_TABLE_DEPTH = pms_pkg::EXP_DEPTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [pms_pkg::MODE_W-1:0]            mode,
    input  logic [pms_pkg::POS_W-1:0]             position,
    input  logic [pms_pkg::RES_W-1:0]             residue,
    input  logic [pms_pkg::POS_W-1:0]             other_position,
    input  logic [pms_pkg::RES_W-1:0]             other_residue,
    input  logic signed [pms_pkg::VAL_W-1:0]      param_value,
    input  logic signed [pms_pkg::ENERGY_W-1:0]   energy_value,
    input  logic [pms_pkg::RAND_W-1:0]            random_u,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic                                  accepted,
    output logic signed [pms_pkg::DE_W-1:0]       delta_energy,
    output logic signed [pms_pkg::ENERGY_W-1:0]   energy,
    output logic [pms_pkg::RES_W-1:0]             residue_out
);

    localparam int ROWS  = NUM_POS * NUM_RES;
    localparam int CDEP  = ROWS * ROWS;
    localparam int FAW   = $clog2(ROWS);
    localparam int CAW   = $clog2(CDEP);
    localparam int PW    = $clog2(NUM_POS);
    localparam int JW    = PW + 1;
    localparam int RW    = pms_pkg::RES_W;
    localparam int VW    = pms_pkg::VAL_W;
    localparam int EW    = pms_pkg::ENERGY_W;
    localparam int DW    = pms_pkg::DE_W;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_RDOLD  = 3'd1;
    localparam logic [2:0] S_LOOP   = 3'd2;
    localparam logic [2:0] S_DEC    = 3'd3;
    localparam logic [2:0] S_DEC2   = 3'd4;
    localparam logic [2:0] S_FINISH = 3'd5;

    localparam logic signed [EW:0] E_MAX = (EW+1)'((64'sd1 <<< (EW-1)) - 64'sd1);
    localparam logic signed [EW:0] E_MIN = -(EW+1)'(64'sd1 <<< (EW-1));

    // control registers
    logic [2:0]                state_reg, state_next;
    logic signed [EW-1:0]      energy_reg, energy_next;
    logic [NUM_POS-1:0]        valid_reg, valid_next;
    logic                      out_valid_reg, out_valid_next;
    logic                      s1_v_reg, s1_v_next;
    logic                      s2_v_reg, s2_v_next;
    logic                      fld_reg, fld_next;

    // item and datapath registers
    logic [pms_pkg::MODE_W-1:0] mode_reg, mode_next;
    logic [PW-1:0]             pidx_reg, pidx_next;
    logic                      p_ok_reg, p_ok_next;
    logic                      pr_ok_reg, pr_ok_next;
    logic                      q_ok_reg, q_ok_next;
    logic [RW-1:0]             r_reg, r_next;
    logic signed [VW-1:0]      pv_reg, pv_next;
    logic signed [EW-1:0]      ev_reg, ev_next;
    logic [pms_pkg::RAND_W-1:0] u_reg, u_next;
    logic [FAW-1:0]            rn_reg, rn_next;
    logic [FAW-1:0]            pbase_reg, pbase_next;
    logic [FAW-1:0]            qcol_reg, qcol_next;
    logic [CAW-1:0]            base_n_reg, base_n_next;
    logic [CAW-1:0]            base_o_reg, base_o_next;
    logic [JW-1:0]             ji_reg, ji_next;
    logic [FAW-1:0]            colb_i_reg, colb_i_next;
    logic [PW-1:0]             j1_reg, j1_next;
    logic [FAW-1:0]            colb1_reg, colb1_next;
    logic [PW-1:0]             j2_reg, j2_next;
    logic signed [DW-1:0]      acc_reg, acc_next;
    logic                      keep_reg, keep_next;
    logic [RW-1:0]             res_after_reg, res_after_next;
    logic                      acc_o_reg, acc_o_next;
    logic signed [DW-1:0]      de_o_reg, de_o_next;
    logic signed [EW-1:0]      en_o_reg, en_o_next;
    logic [RW-1:0]             res_o_reg, res_o_next;

    // memory ports
    logic                      seq_we;
    logic [RW-1:0]             seq_rd_j, seq_rd_p;
    logic [PW-1:0]             seq_raddr_p;
    logic                      fld_we;
    logic [VW-1:0]             fld_rd_n, fld_rd_o;
    logic [FAW-1:0]            ro_comb;
    logic                      cpl_we;
    logic [CAW-1:0]            cpl_waddr, cpl_raddr_n, cpl_raddr_o;
    logic [VW-1:0]             cpl_rd_n, cpl_rd_o;

    // misc
    logic                      accept_in;
    logic                      issue;
    logic [RW-1:0]             old_eff, seqj_eff;
    logic signed [VW:0]        fdiff, cdiff;
    logic signed [EW:0]        esum;
    logic                      keep;
    pms_pkg::acc_req_t         req;

    assign in_stall  = (state_reg != S_IDLE);
    assign accept_in = in_valid && !in_stall;

    // effective residues: entries never written since reset read as zero
    assign old_eff  = valid_reg[pidx_reg] ? seq_rd_p : '0;
    assign seqj_eff = valid_reg[j1_reg] ? seq_rd_j : '0;
    assign ro_comb  = pbase_reg + FAW'(old_eff);

    assign seq_raddr_p = (state_reg == S_IDLE) ? PW'(position) : pidx_reg;
    assign cpl_waddr   = base_n_next + CAW'(qcol_reg);
    assign cpl_raddr_n = base_n_reg + CAW'(colb1_reg) + CAW'(seqj_eff);
    assign cpl_raddr_o = base_o_reg + CAW'(colb1_reg) + CAW'(seqj_eff);

    assign fdiff = $signed({fld_rd_o[VW-1], fld_rd_o}) - $signed({fld_rd_n[VW-1], fld_rd_n});
    assign cdiff = $signed({cpl_rd_o[VW-1], cpl_rd_o}) - $signed({cpl_rd_n[VW-1], cpl_rd_n});
    assign esum  = $signed({energy_reg[EW-1], energy_reg}) + (EW+1)'(acc_reg);

    assign req.de = acc_reg;
    assign req.u  = u_reg;

    pms_ram #(.WIDTH(RW), .DEPTH(NUM_POS)) u_seq_ram (
        .clk     (clk),
        .we      (seq_we),
        .waddr   (pidx_reg),
        .wdata   (r_reg),
        .raddr_a (ji_reg[PW-1:0]),
        .rdata_a (seq_rd_j),
        .raddr_b (seq_raddr_p),
        .rdata_b (seq_rd_p)
    );

    pms_ram #(.WIDTH(VW), .DEPTH(ROWS)) u_field_ram (
        .clk     (clk),
        .we      (fld_we),
        .waddr   (rn_reg),
        .wdata   (pv_reg),
        .raddr_a (rn_reg),
        .rdata_a (fld_rd_n),
        .raddr_b (ro_comb),
        .rdata_b (fld_rd_o)
    );

    pms_ram #(.WIDTH(VW), .DEPTH(CDEP)) u_coupling_ram (
        .clk     (clk),
        .we      (cpl_we),
        .waddr   (cpl_waddr),
        .wdata   (pv_reg),
        .raddr_a (cpl_raddr_n),
        .rdata_a (cpl_rd_n),
        .raddr_b (cpl_raddr_o),
        .rdata_b (cpl_rd_o)
    );

    pms_accept #(.EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)) u_accept (
        .clk  (clk),
        .req  (req),
        .keep (keep)
    );

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        energy_next    = energy_reg;
        valid_next     = valid_reg;
        out_valid_next = out_valid_reg;
        s1_v_next      = s1_v_reg;
        s2_v_next      = s2_v_reg;
        fld_next       = fld_reg;
        mode_next      = mode_reg;
        pidx_next      = pidx_reg;
        p_ok_next      = p_ok_reg;
        pr_ok_next     = pr_ok_reg;
        q_ok_next      = q_ok_reg;
        r_next         = r_reg;
        pv_next        = pv_reg;
        ev_next        = ev_reg;
        u_next         = u_reg;
        rn_next        = rn_reg;
        pbase_next     = pbase_reg;
        qcol_next      = qcol_reg;
        base_n_next    = CAW'(rn_reg) * CAW'(ROWS);
        base_o_next    = base_o_reg;
        ji_next        = ji_reg;
        colb_i_next    = colb_i_reg;
        j1_next        = j1_reg;
        colb1_next     = colb1_reg;
        j2_next        = j2_reg;
        acc_next       = acc_reg;
        keep_next      = keep_reg;
        res_after_next = res_after_reg;
        acc_o_next     = acc_o_reg;
        de_o_next      = de_o_reg;
        en_o_next      = en_o_reg;
        res_o_next     = res_o_reg;
        seq_we         = 1'b0;
        fld_we         = 1'b0;
        cpl_we         = 1'b0;
        issue          = 1'b0;

        // output register drains independently
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept_in)
                begin
                    mode_next   = mode;
                    pidx_next   = PW'(position);
                    p_ok_next   = 32'(position) < NUM_POS;
                    pr_ok_next  = (32'(position) < NUM_POS) && (32'(residue) < NUM_RES);
                    q_ok_next   = (32'(other_position) < NUM_POS)
                                  && (32'(other_residue) < NUM_RES);
                    r_next      = residue;
                    pv_next     = param_value;
                    ev_next     = energy_value;
                    u_next      = random_u;
                    pbase_next  = FAW'(PW'(position)) * FAW'(NUM_RES);
                    rn_next     = FAW'(PW'(position)) * FAW'(NUM_RES) + FAW'(residue);
                    qcol_next   = FAW'(PW'(other_position)) * FAW'(NUM_RES)
                                  + FAW'(other_residue);
                    ji_next     = '0;
                    colb_i_next = '0;
                    state_next  = S_RDOLD;
                end
            end
            S_RDOLD:
            begin
                acc_next  = '0;
                keep_next = 1'b0;
                res_after_next = p_ok_reg ? old_eff : '0;
                base_o_next    = CAW'(ro_comb) * CAW'(ROWS);
                state_next     = S_FINISH;
                priority if (mode_reg == pms_pkg::MODE_FIELD)
                begin
                    fld_we = pr_ok_reg;
                end
                else if (mode_reg == pms_pkg::MODE_COUPLING)
                begin
                    cpl_we = pr_ok_reg && q_ok_reg;
                end
                else if (mode_reg == pms_pkg::MODE_SET_RES)
                begin
                    if (pr_ok_reg)
                    begin
                        seq_we                = 1'b1;
                        valid_next[pidx_reg]  = 1'b1;
                        res_after_next        = r_reg;
                    end
                end
                else if (mode_reg == pms_pkg::MODE_SET_ENERGY)
                begin
                    energy_next = ev_reg;
                end
                else if (mode_reg == pms_pkg::MODE_TRIAL)
                begin
                    if (pr_ok_reg)
                    begin
                        issue      = 1'b1;
                        fld_next   = 1'b1;
                        s2_v_next  = 1'b0;
                        state_next = S_LOOP;
                    end
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_LOOP:
            begin
                issue     = ji_reg < JW'(NUM_POS);
                s2_v_next = s1_v_reg;
                j2_next   = j1_reg;
                fld_next  = 1'b0;
                acc_next  = acc_reg
                            + (fld_reg ? DW'(fdiff) : '0)
                            + ((s2_v_reg && (j2_reg != pidx_reg)) ? DW'(cdiff) : '0);
                if (!s1_v_reg && !s2_v_reg && !fld_reg)
                begin
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                state_next = S_DEC2;
            end
            S_DEC2:
            begin
                keep_next = keep;
                if (keep)
                begin
                    if (esum > E_MAX)
                    begin
                        energy_next = EW'(E_MAX);
                    end
                    else if (esum < E_MIN)
                    begin
                        energy_next = EW'(E_MIN);
                    end
                    else
                    begin
                        energy_next = EW'(esum);
                    end
                    seq_we               = 1'b1;
                    valid_next[pidx_reg] = 1'b1;
                    res_after_next       = r_reg;
                end
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    acc_o_next     = keep_reg;
                    de_o_next      = acc_reg;
                    en_o_next      = energy_reg;
                    res_o_next     = res_after_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // sequence read issue for the position loop
        if (state_reg == S_RDOLD || state_reg == S_LOOP)
        begin
            s1_v_next = issue;
            if (issue)
            begin
                j1_next     = ji_reg[PW-1:0];
                colb1_next  = colb_i_reg;
                ji_next     = ji_reg + JW'(1);
                colb_i_next = colb_i_reg + FAW'(NUM_RES);
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            energy_reg    <= '0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
            s1_v_reg      <= 1'b0;
            s2_v_reg      <= 1'b0;
            fld_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            energy_reg    <= energy_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
            s1_v_reg      <= s1_v_next;
            s2_v_reg      <= s2_v_next;
            fld_reg       <= fld_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        mode_reg      <= mode_next;
        pidx_reg      <= pidx_next;
        p_ok_reg      <= p_ok_next;
        pr_ok_reg     <= pr_ok_next;
        q_ok_reg      <= q_ok_next;
        r_reg         <= r_next;
        pv_reg        <= pv_next;
        ev_reg        <= ev_next;
        u_reg         <= u_next;
        rn_reg        <= rn_next;
        pbase_reg     <= pbase_next;
        qcol_reg      <= qcol_next;
        base_n_reg    <= base_n_next;
        base_o_reg    <= base_o_next;
        ji_reg        <= ji_next;
        colb_i_reg    <= colb_i_next;
        j1_reg        <= j1_next;
        colb1_reg     <= colb1_next;
        j2_reg        <= j2_next;
        acc_reg       <= acc_next;
        keep_reg      <= keep_next;
        res_after_reg <= res_after_next;
        acc_o_reg     <= acc_o_next;
        de_o_reg      <= de_o_next;
        en_o_reg      <= en_o_next;
        res_o_reg     <= res_o_next;
    end

    assign out_valid    = out_valid_reg;
    assign accepted     = acc_o_reg;
    assign delta_energy = de_o_reg;
    assign energy       = en_o_reg;
    assign residue_out  = res_o_reg;

    // an accepted item always starts with the residue read
    a_accept_rdold: assert property (@(posedge clk) disable iff (!rst_n)
        accept_in |=> state_reg == S_RDOLD)
        else $error("item accept did not start the residue read");

    // the position loop only runs for a trial
    a_loop_trial: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_LOOP |-> mode_reg == pms_pkg::MODE_TRIAL)
        else $error("position loop entered outside a trial");

    // decision stage follows the scale stage of the acceptance unit
    a_dec_order: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DEC2 |-> $past(state_reg) == S_DEC)
        else $error("decision taken without the scale cycle");

endmodule
